// File: rtl/swm_pkg.sv
package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;

  // Control that every cell in the chain sees in the same cycle.
  typedef struct packed {
    logic push;   // a word is taken this cycle
    logic clear;  // the word starts a new sequence
    logic drop;   // the front entry leaves, so every cell takes its neighbor's entry
  } swm_ctrl_t;

endpackage

// File: rtl/swm_cell.sv
module swm_cell #(
  parameter int PW = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  swm_pkg::swm_ctrl_t                ctrl,
  input  logic signed [swm_pkg::DATA_W-1:0] x,
  input  logic [PW-1:0]                     sp_new,
  input  logic                              prev_keep,
  input  logic                              next_mid_v,
  input  logic signed [swm_pkg::DATA_W-1:0] next_mid_val,
  input  logic [PW-1:0]                     next_mid_pos,
  output logic                              keep,
  output logic                              mid_v,
  output logic signed [swm_pkg::DATA_W-1:0] mid_val,
  output logic [PW-1:0]                     mid_pos,
  output logic                              held_v,
  output logic [PW-1:0]                     held_pos
);

  logic                              v;
  logic signed [swm_pkg::DATA_W-1:0] val;
  logic [PW-1:0]                     pos;
  logic                              ins;

  // Entries hold non-rising values from front to back, so the kept entries
  // form a prefix and the new sample lands in the first cell that is not kept.
  assign keep    = v && !ctrl.clear && !(ctrl.push && (val < x));
  assign ins     = ctrl.push && !keep && prev_keep;
  assign mid_v   = keep || ins;
  assign mid_val = keep ? val : x;
  assign mid_pos = keep ? pos : sp_new;

  assign held_v   = v;
  assign held_pos = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ctrl.drop) begin
      v <= next_mid_v;
    end else begin
      v <= mid_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.drop) begin
      val <= next_mid_val;
      pos <= next_mid_pos;
    end else begin
      val <= mid_val;
      pos <= mid_pos;
    end
  end

endmodule

// File: rtl/sliding_window_maximum_unit.sv
// window_max of a sample is registered and shown in the cycle after the sample word is taken.
// Throughput: one sample per cycle while window_max is not held by out_stall and no trim is in progress.
// After window_size is lowered, the front is trimmed one entry per cycle, with
// in_stall high until it is done.
// Reset (rst, synchronous, active high) empties the chain, clears the counters and
// out_valid, and sets the stored window size (win_reg) to 1.
module sliding_window_maximum_unit #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [swm_pkg::DATA_W-1:0] sample,
  input  logic                              start_req,
  input  logic                              in_valid,
  output logic                              in_stall,
  output logic signed [swm_pkg::DATA_W-1:0] window_max,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  logic [swm_pkg::CFG_W-1:0]         window_size,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);

  localparam int PW = $clog2(2 * WINDOW_MAX);
  localparam int CW = $clog2(WINDOW_MAX + 1);

  logic [swm_pkg::CFG_W-1:0] win_reg;
  logic [CW-1:0]             w_eff;
  logic [PW-1:0]             sp;
  logic [PW-1:0]             sp_next;
  logic [PW-1:0]             ref_sp;
  logic [CW-1:0]             seen;
  logic [CW-1:0]             seen_next;
  logic [PW-1:0]             front_age;
  logic [PW-1:0]             trim_age;
  logic                      trim;
  logic                      accept;
  logic                      result;
  logic                      drop_push;
  swm_pkg::swm_ctrl_t        ctrl;

  logic                              keep_chain [0:WINDOW_MAX];
  logic                              mid_v      [0:WINDOW_MAX];
  logic signed [swm_pkg::DATA_W-1:0] mid_val    [0:WINDOW_MAX];
  logic [PW-1:0]                     mid_pos    [0:WINDOW_MAX];
  logic                              held_v     [0:WINDOW_MAX-1];
  logic [PW-1:0]                     held_pos   [0:WINDOW_MAX-1];
  logic                              front_v;
  logic [PW-1:0]                     front_pos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= swm_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      win_reg <= window_size;
    end
  end

  always_comb begin
    if (win_reg == '0) begin
      w_eff = CW'(1);
    end else if (32'(win_reg) > 32'(WINDOW_MAX)) begin
      w_eff = CW'(WINDOW_MAX);
    end else begin
      w_eff = CW'(win_reg);
    end
  end

  // With no word in flight the chain keeps the front in step with the window:
  // an entry that the next sample would find too old is removed now.
  assign trim_age = sp - front_pos;
  assign trim     = front_v && (32'(trim_age) >= 32'(w_eff) - 32'd1);

  assign in_stall = trim || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign sp_next = start_req ? '0 : sp + PW'(1);
  assign ref_sp  = accept ? sp_next : sp;

  always_comb begin
    if (start_req) begin
      seen_next = CW'(1);
    end else if (seen >= w_eff) begin
      seen_next = w_eff;
    end else begin
      seen_next = seen + CW'(1);
    end
  end

  assign result = seen_next >= w_eff;

  // After the push, the front entry is dropped once it is the oldest sample of the window.
  assign front_age = ref_sp - mid_pos[0];
  assign drop_push = mid_v[0] && (32'(front_age) >= 32'(w_eff) - 32'd1);

  assign ctrl.push  = accept;
  assign ctrl.clear = accept && start_req;
  assign ctrl.drop  = accept ? drop_push : trim;

  assign keep_chain[0]      = 1'b1;
  assign mid_v[WINDOW_MAX]   = 1'b0;
  assign mid_val[WINDOW_MAX] = '0;
  assign mid_pos[WINDOW_MAX] = '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell #(
      .PW (PW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .x            (sample),
      .sp_new       (sp_next),
      .prev_keep    (keep_chain[i]),
      .next_mid_v   (mid_v[i+1]),
      .next_mid_val (mid_val[i+1]),
      .next_mid_pos (mid_pos[i+1]),
      .keep         (keep_chain[i+1]),
      .mid_v        (mid_v[i]),
      .mid_val      (mid_val[i]),
      .mid_pos      (mid_pos[i]),
      .held_v       (held_v[i]),
      .held_pos     (held_pos[i])
    );
  end

  // The trim decision looks at the stored front entry, not at the push path.
  assign front_v   = held_v[0];
  assign front_pos = held_pos[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sp   <= '0;
      seen <= '0;
    end else if (accept) begin
      sp   <= sp_next;
      seen <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result) begin
      window_max <= mid_val[0];
    end
  end

endmodule
